### hw/rtl/fifo_queue_with_removal_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef FIFO_QUEUE_WITH_REMOVAL_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVAL_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define FQR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that, when seen, must be followed by another in the next cycle.
`define FQR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// A condition that, when seen, implies another in the same cycle.
`define FQR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fqr_pkg.sv
// Operation codes, status codes and field widths of the handle queue.
`default_nettype none

package fqr_pkg;

    localparam int OP_W           = 2;
    localparam int STATUS_W       = 2;
    localparam int HANDLE_FIELD_W = 16;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_ENQUEUE = 2'd0;
    localparam op_t OP_DEQUEUE = 2'd1;
    localparam op_t OP_PURGE   = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_FULL    = 2'd1;
    localparam status_t STATUS_EMPTY   = 2'd2;
    localparam status_t STATUS_MISSING = 2'd3;

    // Input transfer: operation then handle, padded to three bytes.
    localparam int IN_TDATA_W = 24;

endpackage

`default_nettype wire

### hw/rtl/fifo_queue_with_removal.sv
// Bounded FIFO of process handles with removal of the first matching handle.
`default_nettype none

`include "fifo_queue_with_removal_defines.svh"

// The block keeps up to QUEUE_DEPTH handles in arrival order in a single
// synchronous memory (one write port, one read port, registered read data)
// and answers every input transfer with exactly one result transfer.
// Enqueue writes the handle at the tail in the cycle it is accepted; a full
// queue drops it and reports a full status. Dequeue and purge share one pass
// over the stored entries: each cycle the pass reads the next entry, and once
// the entry to remove has been seen (the head for dequeue, the first equal
// handle for purge) every later entry is written back one place toward the
// head, so the search and the gap closing finish together. An enqueue, an
// unused operation code, or a dequeue or purge on an empty queue goes from
// idle straight to the result state; a dequeue or purge on a non-empty
// queue first passes through the scan state, which reads one entry per cycle
// on the memory port. The result state loads the output register once that
// register is free and then returns to idle. Items are handled one at a
// time; the result sits in an output register, so the next transfer may be
// accepted while the previous result waits for the sink. The count in the
// result is the number of entries after the operation and the empty flag is
// set when that count is zero. Handles are kept to their low HANDLE_WIDTH bits.
module fifo_queue_with_removal #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] operation, [17:2] handle, [23:18] zero
    input  wire logic [fqr_pkg::IN_TDATA_W-1:0] s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] status, [17:2] handle_out, then count_out ($clog2(QUEUE_DEPTH+1)
    // bits), then is_empty, then zero up to a whole byte
    output logic [((fqr_pkg::STATUS_W + fqr_pkg::HANDLE_FIELD_W
                    + $clog2(QUEUE_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int HF_W   = fqr_pkg::HANDLE_FIELD_W;
    localparam int KEEP_W = (HANDLE_WIDTH < HF_W) ? HANDLE_WIDTH : HF_W;
    localparam int OUT_W  = fqr_pkg::STATUS_W + HF_W + CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    // Input field split.
    fqr_pkg::op_t      s_op;
    logic [HF_W-1:0]   s_handle;
    logic [HANDLE_WIDTH-1:0] s_key;
    logic              s_fire;

    assign s_op     = s_axis_tdata[fqr_pkg::OP_W-1:0];
    assign s_handle = s_axis_tdata[fqr_pkg::OP_W +: HF_W];
    assign s_fire   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s_key = '0;
        s_key[KEEP_W-1:0] = s_handle[KEEP_W-1:0];
    end

    // Control and working registers.
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    pend_reg, pend_next;
    logic [AW-1:0]           pend_idx_reg, pend_idx_next;
    logic                    found_reg, found_next;
    logic                    is_dequeue_reg, is_dequeue_next;
    logic [HANDLE_WIDTH-1:0] key_reg, key_next;
    logic [HANDLE_WIDTH-1:0] hout_reg, hout_next;
    fqr_pkg::status_t        status_reg, status_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    fqr_pkg::status_t        m_status_reg, m_status_next;
    logic [HF_W-1:0]         m_handle_reg, m_handle_next;
    logic [CW-1:0]           m_count_reg, m_count_next;
    logic                    m_empty_reg, m_empty_next;

    // Handle storage and its ports.
    logic [HANDLE_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [HANDLE_WIDTH-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [HANDLE_WIDTH-1:0] mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    logic [HF_W-1:0] hout_field;

    always_comb begin
        hout_field = '0;
        hout_field[KEEP_W-1:0] = hout_reg[KEEP_W-1:0];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        is_dequeue_next = is_dequeue_reg;
        key_next        = key_reg;
        hout_next       = hout_reg;
        status_next     = status_reg;

        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_handle_next = m_handle_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;

        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = s_key;
        mem_re    = 1'b0;
        mem_raddr = rd_idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    hout_next       = '0;
                    status_next     = fqr_pkg::STATUS_OK;
                    key_next        = s_key;
                    is_dequeue_next = (s_op == fqr_pkg::OP_DEQUEUE);
                    rd_idx_next     = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    state_next      = ST_RESULT;
                    case (s_op)
                        fqr_pkg::OP_ENQUEUE: begin
                            if (count_reg >= DEPTH_C) begin
                                status_next = fqr_pkg::STATUS_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        fqr_pkg::OP_DEQUEUE, fqr_pkg::OP_PURGE: begin
                            if (count_reg == '0) begin
                                status_next = fqr_pkg::STATUS_EMPTY;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            // Unused code: the queue is left as it is.
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue side: one read per cycle through the stored entries.
                if (rd_idx_reg != count_reg) begin
                    mem_re        = 1'b1;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[AW-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                // Return side: close the gap behind the removed entry.
                if (pend_reg) begin
                    if (found_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_idx_reg - AW'(1);
                        mem_wdata = mem_rdata_reg;
                    end else if (is_dequeue_reg || (mem_rdata_reg == key_reg)) begin
                        found_next = 1'b1;
                        hout_next  = mem_rdata_reg;
                    end
                end
                if (!pend_reg && (rd_idx_reg == count_reg)) begin
                    state_next = ST_RESULT;
                    if (found_reg) begin
                        count_next = count_reg - CW'(1);
                    end else begin
                        status_next = fqr_pkg::STATUS_MISSING;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_handle_next = hout_field;
                    m_count_next  = count_reg;
                    m_empty_next  = (count_reg == '0);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        pend_idx_reg   <= pend_idx_next;
        is_dequeue_reg <= is_dequeue_next;
        key_reg        <= key_next;
        hout_reg       <= hout_next;
        status_reg     <= status_next;
        m_status_reg   <= m_status_next;
        m_handle_reg   <= m_handle_next;
        m_count_reg    <= m_count_next;
        m_empty_reg    <= m_empty_next;
    end

    assign m_axis_tvalid = m_valid_reg;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[OUT_W-1:0] = {m_empty_reg, m_count_reg, m_handle_reg, m_status_reg};
    end

    // Conditions watched by the assertions below.
    logic scan_start;
    logic full_shown;

    assign scan_start = s_fire && (count_reg != '0)
                        && ((s_op == fqr_pkg::OP_DEQUEUE) || (s_op == fqr_pkg::OP_PURGE));
    assign full_shown = m_valid_reg && (m_status_reg == fqr_pkg::STATUS_FULL);

    // The count never runs past the capacity.
    `FQR_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C, "queue count exceeds capacity")

    // A dequeue or purge on a non-empty queue starts the memory pass.
    `FQR_ASSERT_NEXT(a_scan_start, scan_start, state_reg == ST_SCAN, "scan did not start")

    // A full status is only reported together with a count at capacity.
    `FQR_ASSERT_IMPLY(a_full_count, full_shown, m_count_reg == DEPTH_C, "full below capacity")

endmodule

`default_nettype wire

### tb/fifo_queue_with_removal_tb.sv
// Self-checking testbench for the handle queue with removal of a matching handle.
`default_nettype none

module fifo_queue_with_removal_tb;

    localparam int QUEUE_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 16;
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_TDATA_W  = ((fqr_pkg::STATUS_W + fqr_pkg::HANDLE_FIELD_W
                                    + COUNT_W + 1 + 7) / 8) * 8;
    localparam int ST_W         = fqr_pkg::STATUS_W;
    localparam int HF_W         = fqr_pkg::HANDLE_FIELD_W;

    // The package names only the three real operations; code 3 is the unused one.
    localparam fqr_pkg::op_t OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 400;
    localparam int QUIET_TAIL     = 60;    // last items are sent with no idling at all
    localparam int LONG_HOLD      = 300;   // cycles the sink refuses results once
    localparam int HOLD_AFTER     = 150;   // results seen before the long hold starts
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_UNITS  = 2000000;

    typedef struct {
        logic              pause;   // wait here until every pending result is in
        fqr_pkg::op_t      op;
        logic [15:0]       handle;
    } queue_cmd_t;

    typedef struct packed {
        fqr_pkg::status_t     status;
        logic [15:0]          handle_out;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
    } queue_outcome_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [fqr_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]           m_axis_tdata;

    fifo_queue_with_removal #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with period 8: four units high, four units low.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Commands still to be offered, the golden copy of the queue contents, and
    // the outcomes predicted for transfers that were accepted but not yet answered.
    queue_cmd_t        cmd_backlog[$];
    logic [15:0]       model_q[$];
    queue_outcome_t    outcomes_due[$];

    int                error_count = 0;
    int                results_seen = 0;
    logic              s_took = 1'b0;     // an input transfer happened at the last edge
    logic              quiet_tail = 1'b0; // set once the tail of the stimulus is reached
    logic [15:0]       handle_pool[8];

    // Applies one operation to the golden queue and returns the result it must give.
    // Purge takes the first matching entry from the head, so later duplicates stay.
    function automatic queue_outcome_t apply_queue_op(fqr_pkg::op_t op, logic [15:0] h);
        queue_outcome_t r;
        int             hit;
        r.status     = fqr_pkg::STATUS_OK;
        r.handle_out = '0;
        hit          = -1;
        case (op)
            fqr_pkg::OP_ENQUEUE: begin
                if (model_q.size() >= QUEUE_DEPTH)
                    r.status = fqr_pkg::STATUS_FULL;
                else
                    model_q.push_back(h);
            end
            fqr_pkg::OP_DEQUEUE: begin
                if (model_q.size() == 0)
                    r.status = fqr_pkg::STATUS_EMPTY;
                else
                    r.handle_out = model_q.pop_front();
            end
            fqr_pkg::OP_PURGE: begin
                if (model_q.size() == 0) begin
                    r.status = fqr_pkg::STATUS_EMPTY;
                end else begin
                    for (int i = 0; i < model_q.size(); i++)
                        if (hit < 0 && model_q[i] == h)
                            hit = i;
                    if (hit < 0) begin
                        r.status = fqr_pkg::STATUS_MISSING;
                    end else begin
                        r.handle_out = model_q[hit];
                        model_q.delete(hit);
                    end
                end
            end
            default: ;  // the unused code leaves the queue as it is
        endcase
        r.count    = COUNT_W'(model_q.size());
        r.is_empty = (model_q.size() == 0);
        return r;
    endfunction

    function automatic void add_cmd(fqr_pkg::op_t op, logic [15:0] h);
        queue_cmd_t c;
        c.pause  = 1'b0;
        c.op     = op;
        c.handle = h;
        cmd_backlog.push_back(c);
    endfunction

    function automatic void add_pause();
        queue_cmd_t c;
        c.pause  = 1'b1;
        c.op     = fqr_pkg::OP_ENQUEUE;
        c.handle = '0;
        cmd_backlog.push_back(c);
    endfunction

    // Picks a handle: mostly from a small pool so that purges hit and duplicates
    // occur, now and then any 16-bit value.
    function automatic logic [15:0] pick_handle();
        if ($urandom_range(0, 3) != 0)
            return handle_pool[$urandom_range(0, 7)];
        return 16'($urandom());
    endfunction

    // Driver: changes the input side at the falling edge. An item that is on
    // the bus stays there until the edge at which it was taken; only then is
    // the next one, a pause, or an idle burst chosen.
    int                gap_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_took) begin
            // Still waiting for the block to take the current item.
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (cmd_backlog.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (cmd_backlog[0].pause) begin
            // The sender stays quiet until every result owed has been delivered.
            if (outcomes_due.size() == 0)
                void'(cmd_backlog.pop_front());
            s_axis_tvalid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 6) - 1;
            s_axis_tvalid <= 1'b0;
        end else begin
            queue_cmd_t c;
            c = cmd_backlog.pop_front();
            if (cmd_backlog.size() < QUIET_TAIL)
                quiet_tail = 1'b1;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(fqr_pkg::IN_TDATA_W - 2 - HF_W){1'b0}}, c.handle, c.op};
        end
    end

    // Receiver: random short stalls, plus one long hold during which the
    // sender keeps offering, so that the block fills up and stalls its input.
    int                stall_left = 0;
    int                hold_left = 0;
    logic              hold_done = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: at each rising edge a result transfer is checked against the
    // oldest prediction, and an accepted input transfer adds a new prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                queue_outcome_t got;
                queue_outcome_t want;
                got.status     = m_axis_tdata[ST_W-1:0];
                got.handle_out = m_axis_tdata[ST_W +: HF_W];
                got.count      = m_axis_tdata[ST_W + HF_W +: COUNT_W];
                got.is_empty   = m_axis_tdata[ST_W + HF_W + COUNT_W];
                results_seen++;
                if (outcomes_due.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected: status %0d handle %h count %0d empty %0d",
                             $time, got.status, got.handle_out, got.count, got.is_empty);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.handle_out !== want.handle_out) begin
                        error_count++;
                        $display("%0t: handle_out expected %h actual %h",
                                 $time, want.handle_out, got.handle_out);
                    end
                    if (got.count !== want.count) begin
                        error_count++;
                        $display("%0t: count_out expected %0d actual %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.is_empty !== want.is_empty) begin
                        error_count++;
                        $display("%0t: is_empty expected %0d actual %0d",
                                 $time, want.is_empty, got.is_empty);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outcomes_due.push_back(apply_queue_op(
                    fqr_pkg::op_t'(s_axis_tdata[fqr_pkg::OP_W-1:0]),
                    s_axis_tdata[fqr_pkg::OP_W +: HF_W]));
        end
    end

    // Stimulus and end of run.
    initial begin
        int           counted;
        int           phase_left;
        int           mode;
        int           pick;
        fqr_pkg::op_t op;

        handle_pool[0] = 16'h0000;
        handle_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            handle_pool[i] = 16'($urandom());

        // Directed part: empty queue cases, the unused code, duplicates with a
        // purge that must take the one nearest the head, a purge at the tail, a
        // purge that finds nothing, and dequeues down to empty again.
        add_cmd(fqr_pkg::OP_DEQUEUE, 16'hFFFF);
        add_cmd(fqr_pkg::OP_PURGE,   16'h0000);
        add_cmd(OP_UNUSED,           16'hFFFF);
        add_cmd(fqr_pkg::OP_ENQUEUE, 16'hFFFF);
        add_cmd(fqr_pkg::OP_ENQUEUE, 16'h0000);
        add_cmd(fqr_pkg::OP_ENQUEUE, 16'hAAAA);
        add_cmd(fqr_pkg::OP_ENQUEUE, 16'hFFFF);
        add_cmd(fqr_pkg::OP_ENQUEUE, 16'h5555);
        add_cmd(fqr_pkg::OP_PURGE,   16'hFFFF);
        add_cmd(fqr_pkg::OP_PURGE,   16'h5555);
        add_cmd(fqr_pkg::OP_PURGE,   16'h1234);
        add_cmd(OP_UNUSED,           16'h0000);
        add_cmd(fqr_pkg::OP_DEQUEUE, 16'h0000);
        add_cmd(fqr_pkg::OP_DEQUEUE, 16'hFFFF);
        add_cmd(fqr_pkg::OP_DEQUEUE, 16'h5A5A);
        add_cmd(fqr_pkg::OP_DEQUEUE, 16'h0000);
        add_pause();

        // Random part in phases: filling runs that reach and overrun a full
        // queue, draining runs of dequeues and purges, and mixed runs. Code 3
        // items are sprinkled in but not counted; they leave the queue alone.
        counted    = 0;
        phase_left = 0;
        mode       = 0;
        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(15, 30);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                add_cmd(OP_UNUSED, 16'($urandom()));
            end else begin
                counted++;
                pick = $urandom_range(0, 99);
                case (mode)
                    0: op = (pick < 85) ? fqr_pkg::OP_ENQUEUE :
                            (pick < 93) ? fqr_pkg::OP_DEQUEUE : fqr_pkg::OP_PURGE;
                    1: op = (pick < 15) ? fqr_pkg::OP_ENQUEUE :
                            (pick < 55) ? fqr_pkg::OP_DEQUEUE : fqr_pkg::OP_PURGE;
                    default: op = (pick < 45) ? fqr_pkg::OP_ENQUEUE :
                                  (pick < 70) ? fqr_pkg::OP_DEQUEUE : fqr_pkg::OP_PURGE;
                endcase
                add_cmd(op, pick_handle());
                if (counted == RANDOM_ITEMS / 2)
                    add_pause();
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (cmd_backlog.size() == 0 && !s_axis_tvalid && outcomes_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && outcomes_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every stall at its longest.
    initial begin
        #(TIMEOUT_UNITS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/fqr_pkg.sv
hw/rtl/fifo_queue_with_removal.sv
tb/fifo_queue_with_removal_tb.sv
